// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define LCIF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lcif assertion failed");

// clocked assertion, also checked during reset
`define LCIF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lcif assertion failed");

`endif

// File: rtl/lcif_pkg.sv
// shared constants and types of the level crossing interval finder
// no dependencies
package lcif_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;

    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] STATUS_TWO       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TRUNC     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ONE_NEG   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ONE_NONNEG = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_MIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_MAX = 2'd2;

    typedef struct packed {
        logic start;
    } md_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

// File: rtl/lcif_alu.sv
// shared add/subtract unit used by the multiply and divide steps
// depends on nothing
module lcif_alu #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             sub,
    output logic [WIDTH-1:0] result
);

    assign result = sub ? (op_a - op_b) : (op_a + op_b);

endmodule

// File: rtl/lcif_muldiv.sv
// sequencer computing floor(a * dx / dy) with one shared adder
// depends on lcif_pkg and lcif_alu
module lcif_muldiv
    import lcif_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  md_ctrl_t              ctrl,
    input  logic [DATA_WIDTH-1:0] a_mag,
    input  logic [DATA_WIDTH-1:0] dx_mag,
    input  logic [DATA_WIDTH-1:0] dy_mag,
    output md_stat_t              stat,
    output logic [DATA_WIDTH-1:0] quotient
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     dy_reg, dy_next;
    logic [W-1:0]     hi_reg, hi_next;
    logic [W-1:0]     lo_reg, lo_next;

    logic [W+1:0] alu_a, alu_b, alu_res;
    logic         alu_sub;
    logic         borrow;

    lcif_alu #(.WIDTH(W + 2)) u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_res)
    );

    assign borrow = alu_res[W+1];

    always_comb
    begin
        alu_a   = {2'b00, hi_reg};
        alu_b   = lo_reg[0] ? {2'b00, a_reg} : '0;
        alu_sub = 1'b0;
        if (phase_reg == PH_DIV)
        begin
            alu_a   = {1'b0, hi_reg, lo_reg[W-1]};
            alu_b   = {2'b00, dy_reg};
            alu_sub = 1'b1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        dy_next    = dy_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (ctrl.start)
                begin
                    a_next     = a_mag;
                    dy_next    = dy_mag;
                    hi_next    = '0;
                    lo_next    = dx_mag;
                    cnt_next   = '0;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                hi_next  = alu_res[W:1];
                lo_next  = {alu_res[0], lo_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                hi_next  = borrow ? {hi_reg[W-2:0], lo_reg[W-1]} : alu_res[W-1:0];
                lo_next  = {lo_reg[W-2:0], ~borrow};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        dy_reg <= dy_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = done_reg;
    assign quotient  = lo_reg;

endmodule

// File: rtl/level_crossing_interval_finder.sv
// level crossing interval finder: top level with sample control and result register
// depends on lcif_pkg and lcif_muldiv
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+-------------------------
//  samples  | s_tvalid s_tready s_tdata s_tuser s_tlast | s_tvalid && s_tready
//  results  | m_tvalid m_tready m_tdata m_tuser         | m_tvalid && m_tready
//  config   | cfg_valid cfg_ready cfg_index cfg_data    | cfg_valid && cfg_ready
//
// a sample without a crossing goes through ST_EVAL and ST_FINISH before ready again
// a sample with a sign change also waits in ST_WAIT while the shift-add multiply and
// restoring divide that share one adder run, one bit per cycle
// s_tready is high only when idle; a result waiting in m_tdata stalls only the next
// sample marked last, until the result is taken
// rst_n clears the previous sample, crossing count, axis bounds and m_tvalid, and sets the level to 1 << FRAC_BITS
module level_crossing_interval_finder
    import lcif_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // x_value, y_value, zero pad
    input  logic                   s_tuser,   // scan_start
    input  logic                   s_tlast,   // scan_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // interval_low, interval_high, zero pad
    output logic [STATUS_W-1:0]    m_tuser,   // status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]  cfg_data
);

    localparam int W       = DATA_WIDTH;
    localparam logic [W-1:0] LEVEL_RESET = W'(64'd1 << FRAC_BITS);
    localparam logic [W-1:0] SAT_MAX     = {1'b0, {(W-1){1'b1}}};

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [W-1:0]        level_reg, level_next;
    logic [W-1:0]        axis_min_reg, axis_min_next;
    logic [W-1:0]        axis_max_reg, axis_max_next;
    logic [W-1:0]        prev_x_reg, prev_x_next;
    logic [W-1:0]        prev_y_reg, prev_y_next;
    logic [1:0]          count_reg, count_next;
    logic                out_valid_reg, out_valid_next;

    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    logic                start_reg, start_next;
    logic                end_reg, end_next;
    logic [W-1:0]        first_reg, first_next;
    logic [W-1:0]        second_reg, second_next;
    logic [W-1:0]        out_low_reg, out_low_next;
    logic [W-1:0]        out_high_reg, out_high_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [W:0]   dprev, ndprev, dcur, ddx, nddx, ddy, nddy;
    logic [W-1:0] a_mag, dx_mag, dy_mag;
    logic         on_level, crossing;
    logic [W+1:0] sum;
    logic [W-1:0] sat_val;
    logic         rec_en;
    logic [W-1:0] rec_val;

    md_ctrl_t     md_ctrl;
    md_stat_t     md_stat;
    logic [W-1:0] quotient;

    lcif_muldiv #(.DATA_WIDTH(W)) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (md_ctrl),
        .a_mag    (a_mag),
        .dx_mag   (dx_mag),
        .dy_mag   (dy_mag),
        .stat     (md_stat),
        .quotient (quotient)
    );

    // differences on one extra bit, magnitudes chosen by sign
    assign dprev  = {prev_y_reg[W-1], prev_y_reg} - {level_reg[W-1], level_reg};
    assign ndprev = {level_reg[W-1], level_reg} - {prev_y_reg[W-1], prev_y_reg};
    assign dcur   = {y_reg[W-1], y_reg} - {level_reg[W-1], level_reg};
    assign ddx    = {x_reg[W-1], x_reg} - {prev_x_reg[W-1], prev_x_reg};
    assign nddx   = {prev_x_reg[W-1], prev_x_reg} - {x_reg[W-1], x_reg};
    assign ddy    = {y_reg[W-1], y_reg} - {prev_y_reg[W-1], prev_y_reg};
    assign nddy   = {prev_y_reg[W-1], prev_y_reg} - {y_reg[W-1], y_reg};

    assign a_mag  = dprev[W] ? ndprev[W-1:0] : dprev[W-1:0];
    assign dx_mag = ddx[W] ? nddx[W-1:0] : ddx[W-1:0];
    assign dy_mag = ddy[W] ? nddy[W-1:0] : ddy[W-1:0];

    assign on_level = (y_reg == level_reg);
    assign crossing = (dprev != '0) && (dprev[W] != dcur[W]);

    // two extra bits: a full-range quotient on a large previous x still fits
    assign sum     = {{2{prev_x_reg[W-1]}}, prev_x_reg} + {2'b00, quotient};
    assign sat_val = (!sum[W+1] && (sum[W] || sum[W-1])) ? SAT_MAX : sum[W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        axis_min_next   = axis_min_reg;
        axis_max_next   = axis_max_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_status_next = out_status_reg;
        md_ctrl.start   = 1'b0;
        rec_en          = 1'b0;
        rec_val         = x_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata[W-1:0];
                    y_next     = s_tdata[2*W-1:W];
                    start_next = s_tuser;
                    end_next   = s_tlast;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                prev_x_next = x_reg;
                prev_y_next = y_reg;
                state_next  = ST_FINISH;
                if (start_reg)
                begin
                    count_next = '0;
                end
                else if (on_level)
                begin
                    rec_en = 1'b1;
                end
                else if (crossing)
                begin
                    prev_x_next   = prev_x_reg;
                    prev_y_next   = prev_y_reg;
                    md_ctrl.start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (md_stat.done)
                begin
                    rec_en      = 1'b1;
                    rec_val     = sat_val;
                    prev_x_next = x_reg;
                    prev_y_next = y_reg;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (count_reg)
                        2'd0:
                        begin
                            out_low_next    = axis_min_reg;
                            out_high_next   = axis_max_reg;
                            out_status_next = STATUS_NONE;
                        end
                        2'd1:
                        begin
                            if (first_reg[W-1])
                            begin
                                out_low_next    = first_reg;
                                out_high_next   = axis_max_reg;
                                out_status_next = STATUS_ONE_NEG;
                            end
                            else
                            begin
                                out_low_next    = axis_min_reg;
                                out_high_next   = first_reg;
                                out_status_next = STATUS_ONE_NONNEG;
                            end
                        end
                        2'd2:
                        begin
                            out_low_next    = first_reg;
                            out_high_next   = second_reg;
                            out_status_next = STATUS_TWO;
                        end
                        default:
                        begin
                            out_low_next    = first_reg;
                            out_high_next   = second_reg;
                            out_status_next = STATUS_TRUNC;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // keep the first two crossings, count saturates at three
        if (rec_en)
        begin
            if (count_reg == 2'd0)
            begin
                first_next = rec_val;
            end
            else if (count_reg == 2'd1)
            begin
                second_next = rec_val;
            end
            if (count_reg != 2'd3)
            begin
                count_next = count_reg + 2'd1;
            end
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL:    level_next    = cfg_data;
                CFG_AXIS_MIN: axis_min_next = cfg_data;
                CFG_AXIS_MAX: axis_max_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= LEVEL_RESET;
            axis_min_reg  <= '0;
            axis_max_reg  <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            axis_min_reg  <= axis_min_next;
            axis_max_reg  <= axis_max_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        first_reg      <= first_next;
        second_reg     <= second_next;
        out_low_reg    <= out_low_next;
        out_high_reg   <= out_high_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'({out_high_reg, out_low_reg});
    assign m_tuser   = out_status_reg;

endmodule

// File: rtl/lcif_checker.sv
// port-level checks of the level crossing interval finder, bound to the top level
// depends on lcif_pkg and assert_macros.svh
`include "assert_macros.svh"

module lcif_props
    import lcif_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [TDATA_W-1:0]     s_tdata,
    input logic                   s_tuser,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_W-1:0]     m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [DATA_WIDTH-1:0]  cfg_data
);

    // a stalled result holds its payload
    `LCIF_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> $stable({m_tvalid, m_tdata, m_tuser}))

    // status codes run from two crossings up to one nonnegative crossing
    `LCIF_ASSERT(a_status_code, clk, rst_n, m_tvalid |-> m_tuser <= STATUS_ONE_NONNEG)

    // a sample transfer makes the block busy in the next cycle
    `LCIF_ASSERT(a_busy_after_transfer, clk, rst_n, s_tvalid && s_tready |=> !s_tready)

    // a new result only appears at the end of work on a sample
    `LCIF_ASSERT(a_result_from_work, clk, rst_n, $rose(m_tvalid) |-> !$past(s_tready))

    // no result while in reset
    `LCIF_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid)

endmodule

bind level_crossing_interval_finder lcif_props #(.DATA_WIDTH(DATA_WIDTH)) u_lcif_props (.*);
